FILE: sv/aadgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aadgc_pkg
// Shared widths, register indexes and types of the circle coverage generator.
// ----------------------------------------------------------------------------
package aadgc_pkg;

	localparam int PX_W      = 13;
	localparam int CFG_W     = 16;
	localparam int RAD_W     = 12;
	localparam int COV_W     = 8;
	localparam int IDX_W     = 3;
	localparam int IN_W      = 32;
	localparam int SQ_STEPS  = 25;
	localparam int DIV_STEPS = 8;
	localparam int LAT       = 4 + SQ_STEPS + 4 + DIV_STEPS + 1;

	typedef enum logic [IDX_W-1:0] {
		REG_SHAPE_MODE   = 3'd0,
		REG_CENTER_X     = 3'd1,
		REG_CENTER_Y     = 3'd2,
		REG_OUTER_RADIUS = 3'd3,
		REG_INNER_RADIUS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic             wr;
		logic             full;
		logic [COV_W-1:0] cov;
	} meta_t;

endpackage
`default_nettype wire

FILE: sv/aa_disc_glow_coverage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aa_disc_glow_coverage
// Antialiased disc / radial glow coverage per pixel, fully pipelined.
// ----------------------------------------------------------------------------
// channel  dir  signals                              content
// s_*      in   s_tvalid s_tready s_tdata[31:0]      pixel_x, pixel_y
// m_*      out  m_tvalid m_tready m_tdata m_tuser    coverage, written
// cfg_*    in   cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// One pixel per cycle through 42 register stages, the last of them the output
// register. The length is set by the 25-step square root and the 8-step
// divider, one step a stage.
// The whole pipeline holds while a result waits on m_tready.
// Reset clears the configuration registers and valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module aa_disc_glow_coverage (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [aadgc_pkg::IN_W-1:0]      s_tdata,   // pixel_x, pixel_y, zero pad
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [aadgc_pkg::COV_W-1:0]          m_tdata,   // coverage
	output logic [0:0]                           m_tuser,   // written
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [aadgc_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [aadgc_pkg::CFG_W-1:0]     cfg_data
);
	import aadgc_pkg::*;

	// configuration
	logic                    shape_mode_q;
	logic [CFG_W-1:0]        center_x_q, center_y_q;
	logic [RAD_W-1:0]        outer_q, inner_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_mode_q <= 1'b0;
			center_x_q   <= '0;
			center_y_q   <= '0;
			outer_q      <= '0;
			inner_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_SHAPE_MODE:   shape_mode_q <= cfg_data[0];
				REG_CENTER_X:     center_x_q   <= cfg_data;
				REG_CENTER_Y:     center_y_q   <= cfg_data;
				REG_OUTER_RADIUS: outer_q      <= cfg_data[RAD_W-1:0];
				REG_INNER_RADIUS: inner_q      <= cfg_data[RAD_W-1:0];
				default:          ;
			endcase
		end
	end

	// derived radius terms, 1/32-pixel units
	logic [13:0] ro_c;
	logic [12:0] r2_c, ri_c, rg_c, rc_c, span_c;
	logic [27:0] ro2_q;
	logic [25:0] ri2_q, rg2_q, rc2_q;
	logic        ri_pos_q, glow_ok_q;
	logic [21:0] a_q;
	logic [24:0] top_q;
	logic [49:0] den_q;

	always_comb begin
		r2_c   = {outer_q, 1'b0};
		ro_c   = {1'b0, r2_c} + 14'd16;
		ri_c   = r2_c - 13'd16;
		rg_c   = {outer_q, 1'b0};
		rc_c   = {inner_q, 1'b0};
		span_c = rg_c - rc_c;
	end

	always_ff @(posedge clk) begin
		ro2_q     <= ro_c * ro_c;
		ri2_q     <= ri_c * ri_c;
		ri_pos_q  <= r2_c > 13'd16;
		rg2_q     <= rg_c * rg_c;
		rc2_q     <= rc_c * rc_c;
		glow_ok_q <= rg_c > rc_c;
		a_q       <= {ro_c, 8'd0} - {8'd0, ro_c};
		top_q     <= {rg_c, 12'd0};
		den_q     <= {26'(span_c) * 26'(span_c), 24'd0};
	end

	// pipeline control
	logic           en;
	logic [LAT-1:0] vld_s;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], s_tvalid};
		end
	end

	// s1: offsets from centre
	logic [PX_W-1:0] px_c, py_c;
	logic [18:0]     dx_c, dy_c;
	logic [17:0]     ax_s1, ay_s1;

	always_comb begin
		px_c = s_tdata[PX_W-1:0];
		py_c = s_tdata[2*PX_W-1:PX_W];
		dx_c = {px_c[PX_W-1], px_c, 5'b10000} - {{2{center_x_q[CFG_W-1]}}, center_x_q, 1'b0};
		dy_c = {py_c[PX_W-1], py_c, 5'b10000} - {{2{center_y_q[CFG_W-1]}}, center_y_q, 1'b0};
	end

	// s2: squares, s3: distance squared
	logic [35:0] sx_s2, sy_s2;
	logic [36:0] d2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= dx_c[18] ? 18'(-dx_c) : dx_c[17:0];
			ay_s1 <= dy_c[18] ? 18'(-dy_c) : dy_c[17:0];
			sx_s2 <= ax_s1 * ax_s1;
			sy_s2 <= ay_s1 * ay_s1;
			d2_s3 <= {1'b0, sx_s2} + {1'b0, sy_s2};
		end
	end

	// s4: region flags and root operand
	logic [49:0] op_s4;
	meta_t       meta_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!shape_mode_q) begin
				meta_s4.wr   <= (outer_q != '0) && (d2_s3 < {9'd0, ro2_q});
				meta_s4.full <= ri_pos_q && (d2_s3 <= {11'd0, ri2_q});
				op_s4        <= {7'd0, 43'(d2_s3[26:0]) * 43'd65025};
			end else begin
				meta_s4.wr   <= glow_ok_q && (d2_s3 < {11'd0, rg2_q});
				meta_s4.full <= d2_s3 <= {11'd0, rc2_q};
				op_s4        <= {d2_s3[25:0], 24'd0};
			end
			meta_s4.cov <= '0;
		end
	end

	// square root, two radicand bits a stage
	logic [26:0] sq_rem_s  [0:SQ_STEPS-1];
	logic [24:0] sq_root_s [0:SQ_STEPS-1];
	logic [49:0] sq_op_s   [0:SQ_STEPS-1];
	meta_t       sq_meta_s [0:SQ_STEPS-1];

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		logic [26:0] rin, rt, trial;
		logic [24:0] qin;
		logic [49:0] oin;
		meta_t       min;
		if (g == 0) begin : g_first
			assign rin = '0;
			assign qin = '0;
			assign oin = op_s4;
			assign min = meta_s4;
		end else begin : g_rest
			assign rin = sq_rem_s[g-1];
			assign qin = sq_root_s[g-1];
			assign oin = sq_op_s[g-1];
			assign min = sq_meta_s[g-1];
		end
		always_comb begin
			rt    = {rin[24:0], oin[49:48]};
			trial = {qin, 2'b01};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (rt >= trial) begin
					sq_rem_s[g]  <= rt - trial;
					sq_root_s[g] <= {qin[23:0], 1'b1};
				end else begin
					sq_rem_s[g]  <= rt;
					sq_root_s[g] <= {qin[23:0], 1'b0};
				end
				sq_op_s[g]   <= {oin[47:0], 2'b00};
				sq_meta_s[g] <= min;
			end
		end
	end

	// ceiling root, edge terms, ramp squared
	logic [25:0] c_s;
	meta_t       meta_c, meta_e, meta_m1, meta_m2;
	logic [24:0] u_e;
	logic [49:0] uu_m1;
	logic [57:0] n_m2;
	logic [21:0] diff_c;

	always_comb begin
		diff_c = a_q - c_s[21:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s    <= {1'b0, sq_root_s[SQ_STEPS-1]} + 26'(sq_rem_s[SQ_STEPS-1] != '0);
			meta_c <= sq_meta_s[SQ_STEPS-1];

			meta_e <= meta_c;
			if ({4'd0, a_q} >= c_s) begin
				meta_e.cov <= (diff_c[21:5] > 17'd255) ? 8'd255 : diff_c[12:5];
			end else begin
				meta_e.cov <= '0;
			end
			u_e <= ({1'b0, top_q} >= c_s) ? top_q - c_s[24:0] : '0;

			uu_m1   <= u_e * u_e;
			meta_m1 <= meta_e;
			n_m2    <= {uu_m1, 8'd0} - {8'd0, uu_m1};
			meta_m2 <= meta_m1;
		end
	end

	// quotient by span squared, one bit a stage
	logic [57:0]      dv_rem_s  [0:DIV_STEPS-1];
	logic [COV_W-1:0] dv_q_s    [0:DIV_STEPS-1];
	meta_t            dv_meta_s [0:DIV_STEPS-1];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [57:0]      rin, dsh;
		logic [COV_W-1:0] qin;
		meta_t            min;
		if (j == 0) begin : g_first
			assign rin = n_m2;
			assign qin = '0;
			assign min = meta_m2;
		end else begin : g_rest
			assign rin = dv_rem_s[j-1];
			assign qin = dv_q_s[j-1];
			assign min = dv_meta_s[j-1];
		end
		assign dsh = {8'd0, den_q} << (DIV_STEPS - 1 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[j]  <= (rin >= dsh) ? rin - dsh : rin;
				dv_q_s[j]    <= {qin[COV_W-2:0], rin >= dsh};
				dv_meta_s[j] <= min;
			end
		end
	end

	// output register
	meta_t mo_c;

	assign mo_c = dv_meta_s[DIV_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser[0] <= mo_c.wr;
			if (!mo_c.wr) begin
				m_tdata <= '0;
			end else if (mo_c.full) begin
				m_tdata <= 8'd255;
			end else if (shape_mode_q) begin
				m_tdata <= dv_q_s[DIV_STEPS-1];
			end else begin
				m_tdata <= mo_c.cov;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/aadgc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aadgc_checker
// Port-level checks of the coverage generator, bound to the top level.
// ----------------------------------------------------------------------------
module aadgc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tready,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [aadgc_pkg::COV_W-1:0] m_tdata,
	input wire logic [0:0]                  m_tuser,
	input wire logic                        cfg_ready
);
	import aadgc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("coverage on unwritten pixel");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready not tied to output stall");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind aa_disc_glow_coverage aadgc_checker u_aadgc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.cfg_ready (cfg_ready)
);
`default_nettype wire

FILE: sim/tb_aa_disc_glow_coverage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aa_disc_glow_coverage
// Streams pixel coordinates through the circle coverage generator under
// several disc and glow settings and checks every coverage result in order
// against an exact integer predictor, with random idling and a long stall.
// ----------------------------------------------------------------------------
module tb_aa_disc_glow_coverage;
	import aadgc_pkg::*;

	class coverage_board;
		bit [0:0]          mode;
		logic signed [15:0] cx, cy;
		logic [11:0]       rout, rin;
		logic [8:0]        pending[$];
		int                errors;
		int                checked;

		function longint unsigned sqrt_up(longint unsigned v);
			longint unsigned r, b, w;
			r = 0;
			w = v;
			b = 64'd1 << 62;
			while (b > w) b = b >> 2;
			while (b != 0) begin
				if (w >= r + b) begin
					w = w - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			if (r * r < v) r = r + 1;
			return r;
		endfunction

		function void note_pixel(logic signed [12:0] px, logic signed [12:0] py);
			longint dx, dy;
			longint unsigned d2, r2, ro, ri, a, c, rg, rc, span, top, u, den, cov;
			bit wr;
			dx = longint'(px) * 32 + 16 - longint'(cx) * 2;
			dy = longint'(py) * 32 + 16 - longint'(cy) * 2;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			d2 = dx * dx + dy * dy;
			cov = 0;
			wr = 0;
			if (mode == 0) begin
				r2 = longint'(rout) * 2;
				ro = r2 + 16;
				if (rout != 0 && d2 < ro * ro) begin
					wr = 1;
					ri = r2 - 16;
					if (r2 > 16 && d2 <= ri * ri) begin
						cov = 255;
					end else begin
						a = 255 * ro;
						c = sqrt_up(65025 * d2);
						cov = (a >= c) ? ((a - c) >> 5) : 0;
						if (cov > 255) cov = 255;
					end
				end
			end else begin
				rg = longint'(rout) * 2;
				rc = longint'(rin) * 2;
				if (rg > rc && d2 < rg * rg) begin
					wr = 1;
					if (d2 <= rc * rc) begin
						cov = 255;
					end else begin
						span = rg - rc;
						c = sqrt_up(d2 << 24);
						top = rg << 12;
						u = (top >= c) ? top - c : 0;
						den = (span * span) << 24;
						cov = (255 * u * u) / den;
						if (cov > 255) cov = 255;
					end
				end
			end
			pending.push_back({wr, cov[7:0]});
		endfunction

		function void check_result(logic [7:0] cov, logic wr);
			logic [8:0] exp;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result cov=%0d wr=%0d", $time, cov, wr);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (exp[7:0] !== cov) begin
				$display("%0t: coverage expected %0d actual %0d", $time, exp[7:0], cov);
				errors++;
			end
			if (exp[8] !== wr) begin
				$display("%0t: written expected %0d actual %0d", $time, exp[8], wr);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready;
	logic [31:0] s_tdata;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	coverage_board board;
	int          cycles;
	bit          hold_off;
	int          sent;

	aa_disc_glow_coverage i_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb_aa_disc_glow_coverage: FAIL");
			$finish;
		end
	end

	// result side: sample at rising edge, draw stall at falling edge
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser[0]);

	initial begin
		int w;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hold_off = 0;
				m_tready <= 0;
				repeat (200) @(negedge clk);
			end
			w = $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (w == 0) begin
				m_tready <= 1;
			end else begin
				m_tready <= 0;
				repeat (w - 1) @(negedge clk);
				m_tready <= 1;
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, int val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= 16'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SHAPE_MODE:   board.mode = val[0];
			REG_CENTER_X:     board.cx   = 16'(val);
			REG_CENTER_Y:     board.cy   = 16'(val);
			REG_OUTER_RADIUS: board.rout = val[11:0];
			REG_INNER_RADIUS: board.rin  = val[11:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_circle(bit m, int x, int y, int ro, int ri);
		write_reg(REG_SHAPE_MODE, m);
		write_reg(REG_CENTER_X, x);
		write_reg(REG_CENTER_Y, y);
		write_reg(REG_OUTER_RADIUS, ro);
		write_reg(REG_INNER_RADIUS, ri);
		cfg_valid <= 0;
	endtask

	task automatic send_pixel(int px_i, int py_i, bit gaps);
		logic signed [12:0] px, py;
		int w;
		px = 13'(px_i);
		py = 13'(py_i);
		w = gaps ? $urandom_range(0, 3) : 0;
		if (w != 0) begin
			s_tvalid <= 0;
			repeat (w) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {6'd0, py, px};
		do @(posedge clk); while (!s_tready);
		board.note_pixel(px, py);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LAT + 8) @(negedge clk);
	endtask

	// pixels in a square around the circle, in whole pixels from the centre; one in ten anywhere
	task automatic random_near(int n);
		int c0, c1, span;
		c0 = board.cx >>> 4;
		c1 = board.cy >>> 4;
		span = (board.rout >> 4) + 3;
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				send_pixel($urandom, $urandom, 1);
			else
				send_pixel(c0 + $urandom_range(0, 2 * span) - span,
					c1 + $urandom_range(0, 2 * span) - span, $urandom_range(0, 4) != 0);
		end
	endtask

	initial begin
		board = new();
		board.mode = 0; board.cx = 0; board.cy = 0; board.rout = 0; board.rin = 0;
		arst_n = 0; s_tvalid = 0; s_tdata = 0;
		cfg_valid = 0; cfg_index = REG_SHAPE_MODE; cfg_data = 0;
		cycles = 0; hold_off = 0; sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// reset settings: zero radius disc writes nothing
		send_pixel(0, 0, 0);
		send_pixel(-4096, 4095, 0);
		drain();
		set_circle(0, 16'h0088, 16'hFF78, 16'h0050, 0);
		send_pixel(8, -8, 0);
		send_pixel(12, -8, 0);
		send_pixel(13, -8, 0);
		send_pixel(8, -3, 0);
		send_pixel(4095, 4095, 0);
		send_pixel(-4096, -4096, 0);
		send_pixel(4095, -4096, 0);
		send_pixel(-4096, 4095, 0);
		drain();
		// tiny disc where inner edge is not positive
		set_circle(0, 16'h7FFF, 16'h8000, 1, 16'hFFF);
		send_pixel(2047, -2048, 0);
		send_pixel(2048, -2049, 0);
		send_pixel(-1, 0, 0);
		drain();
		// glow core and ramp, then degenerate glow
		set_circle(1, 0, 0, 16'h0FFF, 16'h0080);
		send_pixel(0, 0, 0);
		send_pixel(100, 100, 0);
		send_pixel(200, 0, 0);
		send_pixel(255, 0, 0);
		send_pixel(300, -300, 0);
		drain();
		set_circle(1, 0, 0, 16'h0040, 16'h0040);
		send_pixel(0, 0, 0);
		send_pixel(1, 1, 0);
		drain();
		// random settings
		for (int ph = 0; ph < 10; ph++) begin
			set_circle(ph[0], $urandom_range(0, 65535) & 16'h8FFF | (ph[1] ? 16'h7000 : 0),
				$urandom, $urandom_range(0, 4095) >> $urandom_range(0, 6),
				$urandom_range(0, 4095) >> $urandom_range(2, 8));
			if (ph == 4) hold_off = 1;
			random_near(62);
			drain();
		end
		$display("Covered %0d pixels, %0d results checked,", sent, board.checked);
		$display("over disc, glow, degenerate and extreme centre/radius settings.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb_aa_disc_glow_coverage: PASS");
		else
			$display("tb_aa_disc_glow_coverage: FAIL");
		$finish;
	end
endmodule

FILE: files.f
sv/aadgc_pkg.sv
sv/aa_disc_glow_coverage.sv
sv/aadgc_checker.sv
sim/tb_aa_disc_glow_coverage.sv
